FILE: hw/rtl/iepr_pkg.sv
package iepr_pkg;

  localparam int NUM_VECTORS      = 96;
  localparam int PRIO_BASE_VECTOR = 26;
  localparam int PRIO_LEVELS      = 7;
  localparam int FIELD_BITS       = 4;

  localparam int CMD_W       = 3;
  localparam int VEC_W       = 8;
  localparam int PRIO_W      = 4;
  localparam int STATUS_W    = 2;
  localparam int VIDX_W      = $clog2(NUM_VECTORS);
  localparam int PRIO_FIELDS = NUM_VECTORS - PRIO_BASE_VECTOR;
  localparam int PIDX_W      = $clog2(PRIO_FIELDS);

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 8;

  localparam logic [CMD_W-1:0] CMD_ENABLE    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DISABLE   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CLR_PEND  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SET_PRIO  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SW_TRIG   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_HW_RAISE  = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_VECTOR  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_PRIO    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_UNSUPPORTED = 2'd3;

  typedef struct packed {
    logic                  en;
    logic [PIDX_W-1:0]     idx;
    logic [FIELD_BITS-1:0] data;
  } prio_wr_t;

endpackage

FILE: hw/rtl/iepr_prio_store.sv
module iepr_prio_store (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           rd_en,
  input  logic [iepr_pkg::PIDX_W-1:0]    rd_idx,
  input  iepr_pkg::prio_wr_t             wr,
  output logic [iepr_pkg::FIELD_BITS-1:0] rd_data
);
  import iepr_pkg::*;

  logic [FIELD_BITS-1:0]  mem [PRIO_FIELDS];
  logic [PRIO_FIELDS-1:0] vld_r;
  logic [PRIO_FIELDS-1:0] vld_nxt;
  logic [FIELD_BITS-1:0]  rd_r;
  logic [FIELD_BITS-1:0]  fwd_r;
  logic                   hit_r;
  logic                   rdv_r;

  always_comb begin
    vld_nxt = vld_r;
    if (wr.en) begin
      vld_nxt[wr.idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.idx] <= wr.data;
    end
  end

  // a write landing on the same edge as the read is forwarded
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_r  <= mem[rd_idx];
      rdv_r <= vld_r[rd_idx];
      hit_r <= wr.en && (wr.idx == rd_idx);
      fwd_r <= wr.data;
    end
  end

  always_comb begin
    if (hit_r) begin
      rd_data = fwd_r;
    end else if (rdv_r) begin
      rd_data = rd_r;
    end else begin
      rd_data = '0;
    end
  end

endmodule

FILE: hw/rtl/irq_enable_priority_register_block.sv
// an accepted input transaction passes through the input register and then the output register
// before it is offered as an output transaction; out_tvalid rises once the output register is free
// throughput: one transaction per cycle; the input register and the output register
// both advance every cycle while out_tready is high
// synchronous active-low reset empties the pipeline, clears all enable and pending bits
// and marks every priority field as zero
module irq_enable_priority_register_block (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [2:0] command, [10:3] vector, [14:11] priority_req, [15] zero
  input  logic [iepr_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [1:0] status, [2] vector_enabled, [3] vector_pending, [7:4] hw_priority
  output logic [iepr_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import iepr_pkg::*;

  logic                    in_accept;
  logic                    adv1;
  logic                    s1_v_r;
  logic                    s1_v_nxt;
  logic [CMD_W-1:0]        s1_cmd_r;
  logic [VEC_W-1:0]        s1_vec_r;
  logic [PRIO_W-1:0]       s1_prio_r;
  logic                    out_v_r;
  logic                    out_v_nxt;
  logic [OUT_DATA_W-1:0]   out_data_r;

  logic [CMD_W-1:0]        in_cmd;
  logic [VEC_W-1:0]        in_vec;
  logic                    in_has_prio;
  logic [PIDX_W-1:0]       rd_idx;

  logic [NUM_VECTORS-1:0]  en_r;
  logic [NUM_VECTORS-1:0]  en_nxt;
  logic [NUM_VECTORS-1:0]  pend_r;
  logic [NUM_VECTORS-1:0]  pend_nxt;

  logic                    vec_ok;
  logic                    vec_has_prio;
  logic                    prio_ok;
  logic [VIDX_W-1:0]       vidx;
  logic [STATUS_W-1:0]     status;
  logic                    do_en;
  logic                    do_dis;
  logic                    do_clr;
  logic                    do_raise;
  logic [FIELD_BITS-1:0]   rd_data;
  logic [FIELD_BITS-1:0]   hw_prio;
  logic [OUT_DATA_W-1:0]   result;
  prio_wr_t                wr;

  assign in_cmd    = in_tdata[2:0];
  assign in_vec    = in_tdata[10:3];
  assign adv1      = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || adv1;
  assign in_accept = in_tvalid && in_tready;

  assign in_has_prio = (in_vec >= VEC_W'(PRIO_BASE_VECTOR)) &&
                       (in_vec < VEC_W'(NUM_VECTORS));
  assign rd_idx      = in_has_prio ? PIDX_W'(in_vec - VEC_W'(PRIO_BASE_VECTOR)) : '0;

  assign s1_v_nxt  = in_accept ? 1'b1 : (adv1 ? 1'b0 : s1_v_r);
  assign out_v_nxt = adv1 ? 1'b1 : (out_tready ? 1'b0 : out_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      en_r    <= '0;
      pend_r  <= '0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
      en_r    <= en_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_cmd_r  <= in_cmd;
      s1_vec_r  <= in_vec;
      s1_prio_r <= in_tdata[14:11];
    end
    if (adv1) begin
      out_data_r <= result;
    end
  end

  // decode of the item held in the input register
  assign vec_ok       = s1_vec_r < VEC_W'(NUM_VECTORS);
  assign vec_has_prio = vec_ok && (s1_vec_r >= VEC_W'(PRIO_BASE_VECTOR));
  assign prio_ok      = s1_prio_r < PRIO_W'(PRIO_LEVELS);
  assign vidx         = vec_ok ? s1_vec_r[VIDX_W-1:0] : '0;

  always_comb begin
    if (s1_cmd_r == CMD_SW_TRIG || s1_cmd_r > CMD_HW_RAISE) begin
      status = ST_UNSUPPORTED;
    end else if (!vec_ok) begin
      status = ST_BAD_VECTOR;
    end else if (s1_cmd_r == CMD_SET_PRIO && !prio_ok) begin
      status = ST_BAD_PRIO;
    end else begin
      status = ST_OK;
    end
  end

  assign do_en    = (status == ST_OK) && (s1_cmd_r == CMD_ENABLE);
  assign do_dis   = (status == ST_OK) && (s1_cmd_r == CMD_DISABLE);
  assign do_clr   = (status == ST_OK) && (s1_cmd_r == CMD_CLR_PEND);
  assign do_raise = (status == ST_OK) && (s1_cmd_r == CMD_HW_RAISE);

  always_comb begin
    en_nxt   = en_r;
    pend_nxt = pend_r;
    if (adv1) begin
      if (do_en) begin
        en_nxt[vidx] = 1'b1;
      end
      if (do_dis) begin
        en_nxt[vidx] = 1'b0;
      end
      if (do_clr) begin
        pend_nxt[vidx] = 1'b0;
      end
      if (do_raise) begin
        pend_nxt[vidx] = 1'b1;
      end
    end
  end

  always_comb begin
    wr.en   = adv1 && (status == ST_OK) && (s1_cmd_r == CMD_SET_PRIO) && vec_has_prio;
    wr.idx  = vec_has_prio ? PIDX_W'(s1_vec_r - VEC_W'(PRIO_BASE_VECTOR)) : '0;
    wr.data = FIELD_BITS'(PRIO_W'(PRIO_LEVELS) - s1_prio_r);
  end

  iepr_prio_store u_prio (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_accept),
    .rd_idx  (rd_idx),
    .wr      (wr),
    .rd_data (rd_data)
  );

  always_comb begin
    if (!vec_has_prio) begin
      hw_prio = '0;
    end else if (wr.en) begin
      hw_prio = wr.data;
    end else begin
      hw_prio = rd_data;
    end
  end

  // fields report the state after this transaction, zero for an invalid vector
  always_comb begin
    result      = '0;
    result[1:0] = status;
    if (vec_ok) begin
      result[2]   = en_nxt[vidx];
      result[3]   = pend_nxt[vidx];
      result[7:4] = hw_prio;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: hw/rtl/iepr_checker.sv
module iepr_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [iepr_pkg::IN_DATA_W-1:0]  in_tdata,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [iepr_pkg::OUT_DATA_W-1:0] out_tdata
);
  import iepr_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // an invalid vector reports no enable, pending or priority
  a_bad_vec_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == ST_BAD_VECTOR |-> out_tdata[7:2] == '0)
    else $error("fields set for invalid vector");

  // stored priority is levels minus logical priority, never above the level count
  a_hw_prio_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:4] <= 4'(PRIO_LEVELS))
    else $error("hardware priority out of range");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // with the output register empty the input side always has room
  a_in_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled while output empty");

endmodule

bind irq_enable_priority_register_block iepr_checker u_iepr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: dv/tb_top.sv
module tb_top;
  import iepr_pkg::*;

  // command codes the block has no name for
  localparam logic [CMD_W-1:0] CMD_UNDEF_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNDEF_HI = 3'd7;

  localparam int IDLE_LIMIT   = 1000;
  localparam int LONG_HOLD    = 100;
  localparam int TAIL_CYCLES  = 10;
  localparam int PHASE_ITEMS  = 125;
  localparam int PHASE_COUNT  = 6;

  typedef struct packed {
    logic [FIELD_BITS-1:0] hw_priority;
    logic                  vector_pending;
    logic                  vector_enabled;
    logic [STATUS_W-1:0]   status;
  } irq_response_t;

  class irq_state_tracker;
    bit                    enabled_map [NUM_VECTORS];
    bit                    pending_map [NUM_VECTORS];
    logic [FIELD_BITS-1:0] hw_prio_map [NUM_VECTORS];
    irq_response_t         expected_responses[$];
    int                    errors;

    function new();
      foreach (enabled_map[i]) begin
        enabled_map[i] = 1'b0;
        pending_map[i] = 1'b0;
        hw_prio_map[i] = '0;
      end
      errors = 0;
    endfunction

    function void record_command(logic [CMD_W-1:0] cmd, logic [VEC_W-1:0] vec,
                                 logic [PRIO_W-1:0] prio);
      irq_response_t rsp;
      bit            valid;
      rsp   = '0;
      valid = vec < NUM_VECTORS;
      if (cmd == CMD_SW_TRIG || cmd > CMD_HW_RAISE) begin
        rsp.status = ST_UNSUPPORTED;
      end else if (!valid) begin
        rsp.status = ST_BAD_VECTOR;
      end else begin
        rsp.status = ST_OK;
        case (cmd)
          CMD_ENABLE:   enabled_map[vec] = 1'b1;
          CMD_DISABLE:  enabled_map[vec] = 1'b0;
          CMD_CLR_PEND: pending_map[vec] = 1'b0;
          CMD_HW_RAISE: pending_map[vec] = 1'b1;
          CMD_SET_PRIO: begin
            if (prio >= PRIO_LEVELS) begin
              rsp.status = ST_BAD_PRIO;
            end else if (vec >= PRIO_BASE_VECTOR) begin
              // field holds levels minus logical priority
              hw_prio_map[vec] = FIELD_BITS'(PRIO_LEVELS - prio);
            end
          end
          default: ;
        endcase
      end
      if (valid) begin
        rsp.vector_enabled = enabled_map[vec];
        rsp.vector_pending = pending_map[vec];
        rsp.hw_priority    = (vec >= PRIO_BASE_VECTOR) ? hw_prio_map[vec] : '0;
      end
      expected_responses.push_back(rsp);
    endfunction

    function void compare_field(string name, int unsigned exp_val, int unsigned act_val);
      if (exp_val != act_val) begin
        $display("%0t: %s expected %0d actual %0d", $time, name, exp_val, act_val);
        errors++;
      end
    endfunction

    function void check_response(irq_response_t act);
      irq_response_t exp_rsp;
      if (expected_responses.size() == 0) begin
        $display("%0t: unexpected transaction, expected none actual %h", $time, act);
        errors++;
        return;
      end
      exp_rsp = expected_responses.pop_front();
      compare_field("status", exp_rsp.status, act.status);
      compare_field("vector_enabled", exp_rsp.vector_enabled, act.vector_enabled);
      compare_field("vector_pending", exp_rsp.vector_pending, act.vector_pending);
      compare_field("hw_priority", exp_rsp.hw_priority, act.hw_priority);
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;

  irq_state_tracker tracker;
  int               tx_max_gap;
  int               rx_max_stall;
  bit               long_hold_req;
  int               idle_cycles;

  irq_enable_priority_register_block uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
  end

  always #10 clk = ~clk;

  // response monitor and hang watchdog
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      tracker.check_response(irq_response_t'(out_tdata));
    end
    if (rst_n && ((in_tvalid && in_tready) || (out_tvalid && out_tready))) begin
      idle_cycles <= 0;
    end else if (rst_n) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("irq_enable_priority_register_block: mismatch");
        $finish;
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int stall;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      stall = $urandom_range(0, rx_max_stall);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall = LONG_HOLD;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  task automatic send_command(logic [CMD_W-1:0] cmd, logic [VEC_W-1:0] vec,
                              logic [PRIO_W-1:0] prio);
    int gap;
    gap = $urandom_range(0, tx_max_gap);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  <= {1'b0, prio, vec, cmd};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    tracker.record_command(cmd, vec, prio);
  endtask

  task automatic send_random_command();
    logic [CMD_W-1:0]  cmd;
    logic [VEC_W-1:0]  vec;
    logic [PRIO_W-1:0] prio;
    if ($urandom_range(0, 99) < 85) vec = VEC_W'($urandom_range(0, NUM_VECTORS - 1));
    else vec = VEC_W'($urandom_range(NUM_VECTORS, 255));
    if ($urandom_range(0, 99) < 90) cmd = CMD_W'($urandom_range(CMD_ENABLE, CMD_HW_RAISE));
    else cmd = CMD_W'($urandom_range(0, 7));
    if ($urandom_range(0, 99) < 70) prio = PRIO_W'($urandom_range(0, PRIO_LEVELS - 1));
    else prio = PRIO_W'($urandom_range(0, 15));
    send_command(cmd, vec, prio);
  endtask

  // stop offering before waiting so the last transaction is not taken again
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (tracker.expected_responses.size() != 0) @(posedge clk);
  endtask

  initial begin
    tracker       = new();
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    tx_max_gap    = 12;
    rx_max_stall  = 12;
    long_hold_req = 1'b0;
    idle_cycles   = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // register boundaries, field extremes and each error path
    send_command(CMD_ENABLE,   8'd0,   4'd0);
    send_command(CMD_ENABLE,   8'd95,  4'd15);
    send_command(CMD_HW_RAISE, 8'd31,  4'd0);
    send_command(CMD_HW_RAISE, 8'd32,  4'd0);
    send_command(CMD_ENABLE,   8'd64,  4'd0);
    send_command(CMD_SET_PRIO, 8'd26,  4'd0);
    send_command(CMD_SET_PRIO, 8'd95,  4'd6);
    send_command(CMD_SET_PRIO, 8'd34,  4'd3);
    send_command(CMD_SET_PRIO, 8'd33,  4'd1);
    send_command(CMD_SET_PRIO, 8'd25,  4'd5);
    send_command(CMD_SET_PRIO, 8'd40,  4'd7);
    send_command(CMD_SET_PRIO, 8'd40,  4'd15);
    send_command(CMD_CLR_PEND, 8'd31,  4'd0);
    send_command(CMD_DISABLE,  8'd0,   4'd0);
    send_command(CMD_SW_TRIG,  8'd5,   4'd0);
    send_command(CMD_SW_TRIG,  8'd255, 4'd15);
    send_command(CMD_ENABLE,   8'd96,  4'd0);
    send_command(CMD_HW_RAISE, 8'd255, 4'd0);
    send_command(CMD_SET_PRIO, 8'd200, 4'd15);
    send_command(CMD_UNDEF_LO, 8'd10,  4'd0);
    send_command(CMD_UNDEF_HI, 8'd255, 4'd15);
    send_command(CMD_DISABLE,  8'd95,  4'd0);
    send_command(CMD_CLR_PEND, 8'd32,  4'd0);
    send_command(CMD_SET_PRIO, 8'd95,  4'd0);
    wait_drained();

    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      case (ph)
        1: begin
          tx_max_gap   = 0;
          rx_max_stall = 0;
        end
        2: begin
          // sender keeps pushing while the output is held off
          tx_max_gap    = 0;
          rx_max_stall  = 3;
          long_hold_req = 1'b1;
        end
        3: begin
          tx_max_gap   = 12;
          rx_max_stall = 0;
        end
        4: begin
          tx_max_gap   = 2;
          rx_max_stall = 12;
        end
        default: begin
          tx_max_gap   = 12;
          rx_max_stall = 12;
        end
      endcase
      repeat (PHASE_ITEMS) send_random_command();
      if (ph == 3) wait_drained();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.expected_responses.size() != 0) begin
      $display("%0t: leftover transactions expected 0 actual %0d", $time,
               tracker.expected_responses.size());
      tracker.errors++;
    end
    if (tracker.errors == 0) begin
      $display("irq_enable_priority_register_block: match");
    end else begin
      $display("irq_enable_priority_register_block: mismatch");
    end
    $finish;
  end

endmodule
